>>> src/rv32x_pkg.sv
`timescale 1ns / 1ps
// rv32x_pkg: command codes, instruction record and size constants shared by
// the execute unit core, its checker and testbench. depends on nothing.
package rv32x_pkg;

    localparam int DEF_MEM_BYTES = 65536;
    localparam int NUM_REGS      = 32;
    localparam int XLEN          = 32;
    localparam int REG_AW        = 5;
    localparam int PC_W          = 16;
    localparam int IMM_W         = 20;
    localparam int CMD_W         = 4;
    localparam int NUM_BANKS     = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_AND  = 4'd2,
        CMD_SLT  = 4'd3,
        CMD_SLL  = 4'd4,
        CMD_SRA  = 4'd5,
        CMD_ADDI = 4'd6,
        CMD_ANDI = 4'd7,
        CMD_LW   = 4'd8,
        CMD_LB   = 4'd9,
        CMD_SW   = 4'd10,
        CMD_SB   = 4'd11,
        CMD_LUI  = 4'd12,
        CMD_BEQ  = 4'd13
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [IMM_W-1:0]  imm;
    } instr_t;

endpackage

>>> src/rv32_subset_execute_unit_core.sv
`timescale 1ns / 1ps
// rv32_subset_execute_unit_core: execute unit for a subset of rv32i with
// register file and byte data memory in rv32x_ram instances.
// depends on rv32x_pkg and rv32x_ram.
//
// usage
// - s_ channel: one decoded instruction per beat (command, registers,
//   20-bit immediate). m_ channel: one result beat per instruction, in order.
// - cfg channel: writes program_length, always ready; write only when idle.
// - path: execute stage, then result register; lw and lb pass load completion.
// - throughput: 1 beat per cycle while m_ready is high; a load holds s_ready
//   low in the execute stage, since its byte memory read must land before
//   write-back. registers read at acceptance get a same-cycle write forwarded.
// - data memory is four byte banks, so an unaligned word access is a single
//   read or write across all four banks.
// - reset: registers, counter and program_length go to zero, then the data
//   memory is cleared one row per cycle, all MEM_BYTES/4 rows (16384 at the
//   default size), with s_ready low; cfg writes are taken during the sweep.
// - stall: the result register holds one beat while m_ready is low, one
//   instruction waits behind it, then s_ready drops.
module rv32_subset_execute_unit_core #(
    parameter int MEM_BYTES = rv32x_pkg::DEF_MEM_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rv32x_pkg::CMD_W-1:0]   s_command,
    input  logic [rv32x_pkg::REG_AW-1:0]  s_dest_reg,
    input  logic [rv32x_pkg::REG_AW-1:0]  s_src_reg_a,
    input  logic [rv32x_pkg::REG_AW-1:0]  s_src_reg_b,
    input  logic [rv32x_pkg::IMM_W-1:0]   s_immediate,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rv32x_pkg::PC_W-1:0]    m_next_pc,
    output logic [rv32x_pkg::XLEN-1:0]    m_write_value,
    output logic                          m_reg_written,
    output logic                          m_branch_taken,
    output logic                          m_illegal_op,
    output logic                          m_halted,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rv32x_pkg::PC_W-1:0]    cfg_program_length
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROW_W  = ADDR_W - 2;
    localparam int ROWS   = MEM_BYTES / rv32x_pkg::NUM_BANKS;
    localparam int XLEN   = rv32x_pkg::XLEN;
    localparam int PC_W   = rv32x_pkg::PC_W;
    localparam int RAW    = rv32x_pkg::REG_AW;

    // control and config state
    logic                   clr_active_reg;
    logic [ROW_W-1:0]       clr_row_reg;
    logic [PC_W-1:0]        prog_len_reg;
    logic [PC_W-1:0]        pc_reg;
    logic [rv32x_pkg::NUM_REGS-1:0] rf_valid_reg;

    // execute stage
    logic                   s1_valid_reg;
    rv32x_pkg::instr_t      s1_instr_reg;
    logic                   fwd_a_reg;
    logic                   fwd_b_reg;
    logic [XLEN-1:0]        fwd_data_reg;
    logic [RAW-1:0]         s1_b_addr_reg;

    // load completion stage
    logic                   s2_valid_reg;
    logic [RAW-1:0]         s2_rd_reg;
    logic                   s2_word_reg;
    logic [1:0]             s2_off_reg;
    logic [PC_W-1:0]        s2_pc_reg;
    logic                   s2_halt_reg;

    // result register
    logic                   m_valid_reg;
    logic [PC_W-1:0]        m_next_pc_reg;
    logic [XLEN-1:0]        m_write_value_reg;
    logic                   m_reg_written_reg;
    logic                   m_branch_taken_reg;
    logic                   m_illegal_op_reg;
    logic                   m_halted_reg;

    logic                   s_accept;
    logic                   out_free;
    logic                   s1_load;
    logic                   s1_store;
    logic                   s1_done;
    logic                   s2_done;
    logic [RAW-1:0]         rd_b_addr;
    rv32x_pkg::instr_t      in_instr;

    logic [XLEN-1:0]        rf_q_a;
    logic [XLEN-1:0]        rf_q_b;
    logic [XLEN-1:0]        op_a;
    logic [XLEN-1:0]        op_b;
    logic [XLEN-1:0]        i12;
    logic [XLEN-1:0]        sum_ai;
    logic [12:0]            br_mag;
    logic [PC_W-1:0]        pc_br;
    logic [XLEN-1:0]        s1_val;
    logic                   s1_wr;
    logic                   s1_taken;
    logic                   s1_illegal;
    logic [PC_W-1:0]        s1_pc_next;
    logic                   s1_halt;

    logic                   rf_we;
    logic [RAW-1:0]         rf_waddr;
    logic [XLEN-1:0]        rf_wdata;
    logic [XLEN-1:0]        load_val;
    logic [7:0]             load_byte [rv32x_pkg::NUM_BANKS];

    logic [ADDR_W-1:0]      mem_addr;
    logic [ROW_W-1:0]       bank_row   [rv32x_pkg::NUM_BANKS];
    logic [1:0]             bank_k     [rv32x_pkg::NUM_BANKS];
    logic [ROW_W-1:0]       bank_waddr [rv32x_pkg::NUM_BANKS];
    logic [7:0]             bank_wdata [rv32x_pkg::NUM_BANKS];
    logic                   bank_we    [rv32x_pkg::NUM_BANKS];
    logic [7:0]             bank_q     [rv32x_pkg::NUM_BANKS];
    logic                   bank_re;

    assign in_instr = '{
        cmd: rv32x_pkg::cmd_t'(s_command),
        rd:  s_dest_reg,
        ra:  s_src_reg_a,
        rb:  s_src_reg_b,
        imm: s_immediate
    };

    // handshake
    assign out_free = ~m_valid_reg | m_ready;
    assign s1_load  = s1_instr_reg.cmd inside {rv32x_pkg::CMD_LW, rv32x_pkg::CMD_LB};
    assign s1_store = s1_instr_reg.cmd inside {rv32x_pkg::CMD_SW, rv32x_pkg::CMD_SB};
    assign s1_done  = s1_valid_reg & ~s1_load & out_free;
    assign s2_done  = s2_valid_reg & out_free;
    assign s_ready  = ~clr_active_reg &
                      ((~s1_valid_reg & ~s2_valid_reg) | s1_done | s2_done);
    assign s_accept = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    // stores read the data register on the second port
    assign rd_b_addr = (in_instr.cmd inside {rv32x_pkg::CMD_SW, rv32x_pkg::CMD_SB})
                       ? s_dest_reg : s_src_reg_b;

    // register file, two copies for two read ports
    rv32x_ram #(.WIDTH(XLEN), .DEPTH(rv32x_pkg::NUM_REGS)) u_rf_a (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s_accept),
        .raddr (s_src_reg_a),
        .rdata (rf_q_a)
    );

    rv32x_ram #(.WIDTH(XLEN), .DEPTH(rv32x_pkg::NUM_REGS)) u_rf_b (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .re    (s_accept),
        .raddr (rd_b_addr),
        .rdata (rf_q_b)
    );

    // operand select: x0 and never-written registers read zero
    always_comb begin
        if (s1_instr_reg.ra == '0) begin
            op_a = '0;
        end else if (fwd_a_reg) begin
            op_a = fwd_data_reg;
        end else if (rf_valid_reg[s1_instr_reg.ra]) begin
            op_a = rf_q_a;
        end else begin
            op_a = '0;
        end
        if (s1_b_addr_reg == '0) begin
            op_b = '0;
        end else if (fwd_b_reg) begin
            op_b = fwd_data_reg;
        end else if (rf_valid_reg[s1_b_addr_reg]) begin
            op_b = rf_q_b;
        end else begin
            op_b = '0;
        end
    end

    assign i12    = {{(XLEN-12){s1_instr_reg.imm[11]}}, s1_instr_reg.imm[11:0]};
    assign sum_ai = op_a + i12;
    assign br_mag = ~s1_instr_reg.imm[12:0] + 13'd1;
    assign pc_br  = s1_instr_reg.imm[12]
                    ? pc_reg - PC_W'(br_mag[12:2])
                    : pc_reg + PC_W'(s1_instr_reg.imm[11:2]);

    // alu and branch
    always_comb begin
        s1_val     = '0;
        s1_wr      = 1'b0;
        s1_taken   = 1'b0;
        s1_illegal = 1'b0;
        case (s1_instr_reg.cmd)
            rv32x_pkg::CMD_ADD: begin
                s1_val = op_a + op_b;
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_SUB: begin
                s1_val = op_a - op_b;
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_AND: begin
                s1_val = op_a & op_b;
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_SLT: begin
                s1_val = XLEN'($signed(op_a) < $signed(op_b));
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_SLL: begin
                s1_val = op_a << op_b[4:0];
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_SRA: begin
                s1_val = XLEN'($signed(op_a) >>> op_b[4:0]);
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_ADDI: begin
                s1_val = sum_ai;
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_ANDI: begin
                s1_val = op_a & i12;
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_LW, rv32x_pkg::CMD_LB: begin
                s1_wr = 1'b1;
            end
            rv32x_pkg::CMD_SW, rv32x_pkg::CMD_SB: begin
                s1_wr = 1'b0;
            end
            rv32x_pkg::CMD_LUI: begin
                s1_val = {s1_instr_reg.imm, 12'd0};
                s1_wr  = 1'b1;
            end
            rv32x_pkg::CMD_BEQ: begin
                s1_taken = (op_a == op_b);
            end
            default: begin
                s1_illegal = 1'b1;
            end
        endcase
    end

    assign s1_pc_next = s1_illegal ? pc_reg : (s1_taken ? pc_br : pc_reg + PC_W'(1));
    assign s1_halt    = (s1_pc_next >= prog_len_reg);

    // byte banks: bank j holds bytes whose address is j mod 4
    assign mem_addr = sum_ai[ADDR_W-1:0];
    assign bank_re  = s1_valid_reg & s1_load;

    for (genvar j = 0; j < rv32x_pkg::NUM_BANKS; j++) begin : g_bank
        logic [ADDR_W-1:0] byte_addr;
        assign bank_k[j]   = 2'(j) - mem_addr[1:0];
        assign byte_addr   = mem_addr + ADDR_W'(bank_k[j]);
        assign bank_row[j] = byte_addr[ADDR_W-1:2];
        assign bank_waddr[j] = clr_active_reg ? clr_row_reg : bank_row[j];
        assign bank_wdata[j] = clr_active_reg ? 8'd0 : op_b[8*bank_k[j] +: 8];
        assign bank_we[j]    = clr_active_reg |
                               (s1_done & s1_store &
                                ((s1_instr_reg.cmd == rv32x_pkg::CMD_SW) ||
                                 (bank_k[j] == 2'd0)));

        rv32x_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .aclk  (aclk),
            .we    (bank_we[j]),
            .waddr (bank_waddr[j]),
            .wdata (bank_wdata[j]),
            .re    (bank_re),
            .raddr (bank_row[j]),
            .rdata (bank_q[j])
        );

        assign load_byte[j] = bank_q[2'(j) + s2_off_reg];
    end

    assign load_val = s2_word_reg
                      ? {load_byte[3], load_byte[2], load_byte[1], load_byte[0]}
                      : {{(XLEN-8){load_byte[0][7]}}, load_byte[0]};

    // register write-back
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = s1_instr_reg.rd;
        rf_wdata = s1_val;
        if (s2_done) begin
            rf_we    = (s2_rd_reg != '0);
            rf_waddr = s2_rd_reg;
            rf_wdata = load_val;
        end else if (s1_done) begin
            rf_we    = s1_wr & (s1_instr_reg.rd != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            prog_len_reg   <= '0;
            pc_reg         <= '0;
            rf_valid_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
                if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_valid) begin
                prog_len_reg <= cfg_program_length;
            end
            if (rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (s1_valid_reg && (s1_load || s1_done)) begin
                pc_reg <= s1_pc_next;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_valid_reg && (s1_load || s1_done)) begin
                s1_valid_reg <= 1'b0;
            end
            if (bank_re) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_done) begin
                s2_valid_reg <= 1'b0;
            end
            if (s1_done || s2_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_instr_reg  <= in_instr;
            s1_b_addr_reg <= rd_b_addr;
            fwd_a_reg     <= rf_we && (rf_waddr == s_src_reg_a);
            fwd_b_reg     <= rf_we && (rf_waddr == rd_b_addr);
            fwd_data_reg  <= rf_wdata;
        end
        if (bank_re) begin
            s2_rd_reg   <= s1_instr_reg.rd;
            s2_word_reg <= (s1_instr_reg.cmd == rv32x_pkg::CMD_LW);
            s2_off_reg  <= mem_addr[1:0];
            s2_pc_reg   <= s1_pc_next;
            s2_halt_reg <= s1_halt;
        end
        if (s2_done) begin
            m_next_pc_reg      <= s2_pc_reg;
            m_write_value_reg  <= (s2_rd_reg != '0) ? load_val : '0;
            m_reg_written_reg  <= (s2_rd_reg != '0);
            m_branch_taken_reg <= 1'b0;
            m_illegal_op_reg   <= 1'b0;
            m_halted_reg       <= s2_halt_reg;
        end else if (s1_done) begin
            m_next_pc_reg      <= s1_pc_next;
            m_write_value_reg  <= (s1_wr && (s1_instr_reg.rd != '0)) ? s1_val : '0;
            m_reg_written_reg  <= s1_wr && (s1_instr_reg.rd != '0);
            m_branch_taken_reg <= s1_taken;
            m_illegal_op_reg   <= s1_illegal;
            m_halted_reg       <= s1_halt;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_next_pc      = m_next_pc_reg;
    assign m_write_value  = m_write_value_reg;
    assign m_reg_written  = m_reg_written_reg;
    assign m_branch_taken = m_branch_taken_reg;
    assign m_illegal_op   = m_illegal_op_reg;
    assign m_halted       = m_halted_reg;

endmodule

>>> src/rv32x_ram.sv
`timescale 1ns / 1ps
// rv32x_ram: generic simple dual-port ram, one write and one read port,
// registered read data held while no read is issued. no dependencies.
module rv32x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> dv/rv32_subset_execute_unit_checker.sv
`timescale 1ns / 1ps
// rv32_subset_execute_unit_checker: watches the instruction, result and
// program_length channels, predicts every result beat and compares it.
// depends on rv32x_pkg.
module rv32_subset_execute_unit_checker
    import rv32x_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [CMD_W-1:0]  s_command,
    input  logic [REG_AW-1:0] s_dest_reg,
    input  logic [REG_AW-1:0] s_src_reg_a,
    input  logic [REG_AW-1:0] s_src_reg_b,
    input  logic [IMM_W-1:0]  s_immediate,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [PC_W-1:0]   m_next_pc,
    input  logic [XLEN-1:0]   m_write_value,
    input  logic              m_reg_written,
    input  logic              m_branch_taken,
    input  logic              m_illegal_op,
    input  logic              m_halted,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [PC_W-1:0]   cfg_program_length,
    output int                mismatches,
    output int                retired,
    output logic              drained
);

    localparam int MEM_AW = $clog2(DEF_MEM_BYTES);

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic [XLEN-1:0] write_value;
        logic            reg_written;
        logic            branch_taken;
        logic            illegal_op;
        logic            halted;
    } retire_t;

    logic [XLEN-1:0] arch_regs [NUM_REGS];
    logic [7:0]      data_mem [DEF_MEM_BYTES];
    logic [PC_W-1:0] arch_pc;
    logic [PC_W-1:0] program_length;
    retire_t         pending_retires [$];

    function automatic logic [XLEN-1:0] read_reg(input logic [REG_AW-1:0] idx);
        return (idx == '0) ? '0 : arch_regs[idx];
    endfunction

    function automatic retire_t execute_instr(input logic [CMD_W-1:0] cmd,
                                              input logic [REG_AW-1:0] rd,
                                              input logic [REG_AW-1:0] ra,
                                              input logic [REG_AW-1:0] rb,
                                              input logic [IMM_W-1:0] imm);
        logic [XLEN-1:0]   a, b, imm12, imm13, value, store_data, pc_step;
        logic [XLEN-1:0]   full_addr;
        logic [MEM_AW-1:0] byte_addr;
        logic [PC_W-1:0]   pc;
        logic              wr, taken, illegal;
        retire_t           res;
        a          = read_reg(ra);
        b          = read_reg(rb);
        store_data = read_reg(rd);
        imm12      = {{20{imm[11]}}, imm[11:0]};
        imm13      = {{19{imm[12]}}, imm[12:0]};
        full_addr  = a + imm12;
        byte_addr  = full_addr[MEM_AW-1:0];
        value      = '0;
        wr         = 1'b0;
        taken      = 1'b0;
        illegal    = 1'b0;
        pc         = arch_pc;
        case (cmd)
            CMD_ADD: begin
                value = a + b;
                wr = 1'b1;
            end
            CMD_SUB: begin
                value = a - b;
                wr = 1'b1;
            end
            CMD_AND: begin
                value = a & b;
                wr = 1'b1;
            end
            CMD_SLT: begin
                value = {31'b0, $signed(a) < $signed(b)};
                wr = 1'b1;
            end
            CMD_SLL: begin
                value = a << b[4:0];
                wr = 1'b1;
            end
            CMD_SRA: begin
                value = $unsigned($signed(a) >>> b[4:0]);
                wr = 1'b1;
            end
            CMD_ADDI: begin
                value = a + imm12;
                wr = 1'b1;
            end
            CMD_ANDI: begin
                value = a & imm12;
                wr = 1'b1;
            end
            CMD_LW: begin
                for (int k = 0; k < 4; k++) begin
                    value[8*k +: 8] = data_mem[byte_addr];
                    byte_addr = byte_addr + MEM_AW'(1);
                end
                wr = 1'b1;
            end
            CMD_LB: begin
                value = {{24{data_mem[byte_addr][7]}}, data_mem[byte_addr]};
                wr = 1'b1;
            end
            CMD_SW: begin
                for (int k = 0; k < 4; k++) begin
                    data_mem[byte_addr] = store_data[8*k +: 8];
                    byte_addr = byte_addr + MEM_AW'(1);
                end
            end
            CMD_SB: data_mem[byte_addr] = store_data[7:0];
            CMD_LUI: begin
                value = {imm, 12'b0};
                wr = 1'b1;
            end
            CMD_BEQ: begin
                if (a == b) begin
                    taken = 1'b1;
                    // offset in instructions, truncated toward zero
                    if (imm13[XLEN-1]) begin
                        pc_step = ((-imm13) & 32'h1FFF) >> 2;
                        pc = pc - pc_step[PC_W-1:0];
                    end else begin
                        pc_step = imm13 >> 2;
                        pc = pc + pc_step[PC_W-1:0];
                    end
                end
            end
            default: illegal = 1'b1;
        endcase
        if (!illegal && !taken)
            pc = pc + PC_W'(1);
        if (wr && rd != '0) begin
            arch_regs[rd] = value;
        end else begin
            wr = 1'b0;
            value = '0;
        end
        arch_pc = pc;
        res.next_pc      = pc;
        res.write_value  = value;
        res.reg_written  = wr;
        res.branch_taken = taken;
        res.illegal_op   = illegal;
        res.halted       = (pc >= program_length);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        retire_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++)
                arch_regs[i] = '0;
            for (int i = 0; i < DEF_MEM_BYTES; i++)
                data_mem[i] = '0;
            arch_pc = '0;
            program_length = '0;
            pending_retires.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                program_length = cfg_program_length;
            if (m_valid && m_ready) begin
                retired++;
                if (pending_retires.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected, expected none actual %h",
                             $time, {m_next_pc, m_write_value});
                end else begin
                    want = pending_retires.pop_front();
                    check_field("next_pc", XLEN'(want.next_pc), XLEN'(m_next_pc));
                    check_field("write_value", want.write_value, m_write_value);
                    check_field("reg_written", XLEN'(want.reg_written),
                                XLEN'(m_reg_written));
                    check_field("branch_taken", XLEN'(want.branch_taken),
                                XLEN'(m_branch_taken));
                    check_field("illegal_op", XLEN'(want.illegal_op),
                                XLEN'(m_illegal_op));
                    check_field("halted", XLEN'(want.halted), XLEN'(m_halted));
                end
            end
            if (s_valid && s_ready)
                pending_retires.push_back(execute_instr(s_command, s_dest_reg, s_src_reg_a,
                                                        s_src_reg_b, s_immediate));
        end
        drained <= (pending_retires.size() == 0);
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives instructions and program_length writes into the execute
// unit core and gives the verdict. depends on rv32x_pkg,
// rv32_subset_execute_unit_core and rv32_subset_execute_unit_checker.
module testbench;
    import rv32x_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd14;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int IDLE_PCT       = 13;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command = '0;
    logic [REG_AW-1:0] s_dest_reg = '0;
    logic [REG_AW-1:0] s_src_reg_a = '0;
    logic [REG_AW-1:0] s_src_reg_b = '0;
    logic [IMM_W-1:0]  s_immediate = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PC_W-1:0]   m_next_pc;
    logic [XLEN-1:0]   m_write_value;
    logic              m_reg_written;
    logic              m_branch_taken;
    logic              m_illegal_op;
    logic              m_halted;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [PC_W-1:0]   cfg_program_length = '0;

    int   mismatches;
    int   retired;
    logic drained;
    int   cycle_count = 0;
    int   send_idle_pct = IDLE_PCT;
    int   length_settings = 0;

    always #5 aclk = ~aclk;

    rv32_subset_execute_unit_core DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_dest_reg         (s_dest_reg),
        .s_src_reg_a        (s_src_reg_a),
        .s_src_reg_b        (s_src_reg_b),
        .s_immediate        (s_immediate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_next_pc          (m_next_pc),
        .m_write_value      (m_write_value),
        .m_reg_written      (m_reg_written),
        .m_branch_taken     (m_branch_taken),
        .m_illegal_op       (m_illegal_op),
        .m_halted           (m_halted),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_program_length (cfg_program_length)
    );

    rv32_subset_execute_unit_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_dest_reg         (s_dest_reg),
        .s_src_reg_a        (s_src_reg_a),
        .s_src_reg_b        (s_src_reg_b),
        .s_immediate        (s_immediate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_next_pc          (m_next_pc),
        .m_write_value      (m_write_value),
        .m_reg_written      (m_reg_written),
        .m_branch_taken     (m_branch_taken),
        .m_illegal_op       (m_illegal_op),
        .m_halted           (m_halted),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_program_length (cfg_program_length),
        .mismatches         (mismatches),
        .retired            (retired),
        .drained            (drained)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats retired", cycle_count, retired);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_instr(input logic [CMD_W-1:0] cmd, input logic [REG_AW-1:0] rd,
                              input logic [REG_AW-1:0] ra, input logic [REG_AW-1:0] rb,
                              input logic [IMM_W-1:0] imm);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_dest_reg  <= rd;
        s_src_reg_a <= ra;
        s_src_reg_b <= rb;
        s_immediate <= imm;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_random_instr();
        logic [CMD_W-1:0]  cmd;
        logic [REG_AW-1:0] rd, ra, rb;
        logic [IMM_W-1:0]  imm;
        int                pick;
        pick = $urandom_range(99);
        cmd  = CMD_W'($urandom_range(15));
        rd   = REG_AW'($urandom);
        ra   = REG_AW'($urandom);
        rb   = REG_AW'($urandom);
        imm  = IMM_W'($urandom);
        if (pick < 30) begin
            // loads and stores with offsets in -64..63, mostly based on x0 near address zero
            case ($urandom_range(3))
                0: cmd = CMD_SW;
                1: cmd = CMD_SB;
                2: cmd = CMD_LW;
                default: cmd = CMD_LB;
            endcase
            imm[11:0] = $urandom_range(1) ? 12'($urandom_range(63))
                                          : 12'hFC0 | 12'($urandom_range(63));
            if ($urandom_range(3) != 0)
                ra = '0;
        end else if (pick < 45) begin
            cmd = CMD_BEQ;
            if ($urandom_range(1))
                rb = ra;
        end else if (pick < 95) begin
            cmd = CMD_W'($urandom_range(CMD_ANDI));
            if ($urandom_range(7) == 0)
                cmd = CMD_LUI;
        end
        send_instr(cmd, rd, ra, rb, imm);
    endtask

    task automatic write_program_length(input logic [PC_W-1:0] len);
        cfg_valid          <= 1'b1;
        cfg_program_length <= len;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        length_settings++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (!drained);
    endtask

    // receiver: random stalls, a calm stretch, and long hold-offs
    initial begin : receiver
        int rx_beats;
        int next_holdoff;
        rx_beats = 0;
        next_holdoff = 100;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                rx_beats++;
            if (rx_beats >= next_holdoff) begin
                next_holdoff += 700;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end
            m_ready <= (rx_beats >= 450 && rx_beats < 650) || $urandom_range(99) >= IDLE_PCT;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_program_length(16'hFFFF);
        // backward branch from zero wraps the counter to its top value
        send_instr(CMD_BEQ,  5'd0,  5'd0, 5'd0, 20'h01FFC);
        send_instr(CMD_LUI,  5'd1,  5'd0, 5'd0, 20'hFFFFF);
        send_instr(CMD_ADDI, 5'd2,  5'd0, 5'd0, 20'h007FF);
        send_instr(CMD_ADDI, 5'd3,  5'd0, 5'd0, 20'hFF800);
        send_instr(CMD_ADDI, 5'd0,  5'd1, 5'd0, 20'h00005);
        send_instr(CMD_ADD,  5'd4,  5'd1, 5'd2, 20'h00000);
        send_instr(CMD_SUB,  5'd5,  5'd0, 5'd2, 20'h00000);
        send_instr(CMD_AND,  5'd6,  5'd1, 5'd3, 20'h00000);
        send_instr(CMD_SLT,  5'd7,  5'd3, 5'd2, 20'h00000);
        send_instr(CMD_SLT,  5'd8,  5'd2, 5'd3, 20'h00000);
        send_instr(CMD_ADDI, 5'd9,  5'd0, 5'd0, 20'h0003F);
        send_instr(CMD_SLL,  5'd10, 5'd2, 5'd9, 20'h00000);
        send_instr(CMD_SRA,  5'd11, 5'd1, 5'd9, 20'h00000);
        send_instr(CMD_ANDI, 5'd12, 5'd1, 5'd0, 20'hFFFFF);
        // word store across the top of memory wraps to address zero
        send_instr(CMD_SW,   5'd1,  5'd0, 5'd0, 20'h00FFE);
        send_instr(CMD_LW,   5'd13, 5'd0, 5'd0, 20'h00FFE);
        send_instr(CMD_LB,   5'd14, 5'd0, 5'd0, 20'h00FFF);
        send_instr(CMD_SB,   5'd2,  5'd0, 5'd0, 20'h00000);
        send_instr(CMD_LB,   5'd15, 5'd0, 5'd0, 20'h00000);
        send_instr(CMD_LW,   5'd16, 5'd9, 5'd0, 20'h007FF);
        send_instr(CMD_BEQ,  5'd0,  5'd1, 5'd2, 20'h00008);
        send_instr(CMD_BEQ,  5'd0,  5'd0, 5'd0, 20'h00FFF);
        send_instr(CMD_BEQ,  5'd0,  5'd0, 5'd0, 20'hFFFFF);
        send_instr(CMD_BEQ,  5'd0,  5'd0, 5'd0, 20'h01000);
        send_instr(CMD_UNKNOWN_LO, 5'd17, 5'd1, 5'd2, 20'h12345);
        send_instr(CMD_UNKNOWN_HI, 5'd31, 5'd31, 5'd31, 20'hFFFFF);
        send_instr(CMD_LUI,  5'd31, 5'd0, 5'd0, 20'h80000);
        wait_drained();

        write_program_length(16'h0000);
        repeat (250) send_random_instr();
        wait_drained();

        send_idle_pct = 0;
        write_program_length(16'd700);
        repeat (275) send_random_instr();
        wait_drained();

        send_idle_pct = IDLE_PCT;
        write_program_length(16'hFFFF);
        repeat (250) send_random_instr();
        wait_drained();

        write_program_length(PC_W'($urandom_range(1, 65534)));
        repeat (250) send_random_instr();
        wait_drained();

        repeat (8) @(posedge aclk);
        $display("covered %0d instruction beats: directed corner cases, every operation,",
                 retired);
        $display("unknown codes and random traffic over %0d program_length settings",
                 length_settings);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> rv32_subset_execute_unit_core.f
src/rv32x_pkg.sv
src/rv32x_ram.sv
src/rv32_subset_execute_unit_core.sv
dv/rv32_subset_execute_unit_checker.sv
dv/testbench.sv
